// ===== hdl/dotq_pkg.sv =====
// shared types, constants and helpers for the deadline-ordered timer queue
// used by dotq_seq, the top level and the checker
package dotq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;
  localparam int TIME_W      = 48;
  localparam int DELAY_W     = 32;
  localparam int TAG_W       = 16;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = $clog2(2 * QUEUE_DEPTH);
  localparam int BURST       = (MAX_RESULTS < QUEUE_DEPTH) ? MAX_RESULTS : QUEUE_DEPTH;

  typedef enum logic [1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_REJECTED = 2'd1,
    KIND_EXPIRED  = 2'd2,
    KIND_NONE     = 2'd3
  } kind_t;

  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
  } ram_cmd_t;

  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] deadline;
    logic              last;
  } result_t;

  // ring position: head plus offset, folded back into the storage range
  function automatic logic [ADDR_W-1:0] wrap(input logic [ADDR_W-1:0] head,
                                             input logic [CNT_W-1:0]  off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(head) + SUM_W'(off);
    if (s >= SUM_W'(QUEUE_DEPTH)) begin
      s = s - SUM_W'(QUEUE_DEPTH);
    end
    return s[ADDR_W-1:0];
  endfunction

endpackage

// ===== hdl/dotq_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module dotq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                  wr_data,
  input  logic                              rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/dotq_seq.sv =====
// sequencer for the timer queue: deadline adder, shared deadline comparator,
// ring pointers and the insert / drain loops; uses dotq_pkg
module dotq_seq
  import dotq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic [TIME_W-1:0]  current_time,
  input  logic [DELAY_W-1:0] delay,
  input  logic [TAG_W-1:0]   tag,
  input  logic               out_free,
  input  entry_t             rd_entry,
  output ram_cmd_t           ram,
  output result_t            res
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_ADD      = 7'b0000010,
    S_INS_RD   = 7'b0000100,
    S_INS_CMP  = 7'b0001000,
    S_POLL_RD  = 7'b0010000,
    S_POLL_CMP = 7'b0100000,
    S_FIN      = 7'b1000000
  } state_t;

  state_t             state, state_next;
  logic [TIME_W-1:0]  key, key_next;
  logic [DELAY_W-1:0] delay_r, delay_r_next;
  logic [TAG_W-1:0]   new_tag, new_tag_next;
  logic [CNT_W-1:0]   off, off_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [ADDR_W-1:0]  head, head_next;
  logic               pend_valid, pend_valid_next;
  entry_t             pend, pend_next;
  kind_t              fin_kind, fin_kind_next;
  logic               greater;
  logic [TIME_W:0]    sum;

  assign in_stall = (state != S_IDLE);
  assign greater  = (rd_entry.deadline > key);
  assign sum      = {1'b0, key} + (TIME_W + 1)'(delay_r);

  always_comb begin
    state_next      = state;
    key_next        = key;
    delay_r_next    = delay_r;
    new_tag_next    = new_tag;
    off_next        = off;
    count_next      = count;
    head_next       = head;
    pend_valid_next = pend_valid;
    pend_next       = pend;
    fin_kind_next   = fin_kind;
    ram             = '0;
    res             = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          key_next        = current_time;
          delay_r_next    = delay;
          new_tag_next    = tag;
          off_next        = '0;
          pend_valid_next = 1'b0;
          if (action) begin
            fin_kind_next = KIND_NONE;
            state_next    = S_POLL_RD;
          end else begin
            fin_kind_next = KIND_ACCEPTED;
            state_next    = S_ADD;
          end
        end
      end
      S_ADD: begin
        key_next = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        if (count == CNT_W'(QUEUE_DEPTH)) begin
          fin_kind_next = KIND_REJECTED;
          state_next    = S_FIN;
        end else begin
          off_next   = count;
          state_next = S_INS_RD;
        end
      end
      S_INS_RD: begin
        if (off == '0) begin
          ram.wr_en   = 1'b1;
          ram.wr_addr = wrap(head, '0);
          ram.wr_data = '{deadline: key, tag: new_tag};
          state_next  = S_FIN;
        end else begin
          ram.rd_en   = 1'b1;
          ram.rd_addr = wrap(head, off - CNT_W'(1));
          state_next  = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        ram.wr_en   = 1'b1;
        ram.wr_addr = wrap(head, off);
        if (greater) begin
          ram.wr_data = rd_entry;
          off_next    = off - CNT_W'(1);
          state_next  = S_INS_RD;
        end else begin
          ram.wr_data = '{deadline: key, tag: new_tag};
          state_next  = S_FIN;
        end
      end
      S_POLL_RD: begin
        if (off == count || off == CNT_W'(BURST)) begin
          state_next = S_FIN;
        end else begin
          ram.rd_en   = 1'b1;
          ram.rd_addr = wrap(head, off);
          state_next  = S_POLL_CMP;
        end
      end
      S_POLL_CMP: begin
        if (greater) begin
          state_next = S_FIN;
        end else if (!pend_valid || out_free) begin
          // earlier due entry goes out now, this one is held as lookahead
          if (pend_valid) begin
            res = '{valid: 1'b1, kind: KIND_EXPIRED, tag: pend.tag,
                    deadline: pend.deadline, last: 1'b0};
          end
          pend_next       = rd_entry;
          pend_valid_next = 1'b1;
          fin_kind_next   = KIND_EXPIRED;
          off_next        = off + CNT_W'(1);
          state_next      = S_POLL_RD;
        end
      end
      S_FIN: begin
        if (out_free) begin
          res.valid = 1'b1;
          res.kind  = fin_kind;
          res.last  = 1'b1;
          case (fin_kind)
            KIND_ACCEPTED: begin
              count_next = count + CNT_W'(1);
            end
            KIND_EXPIRED: begin
              res.tag      = pend.tag;
              res.deadline = pend.deadline;
              count_next   = count - off;
              head_next    = wrap(head, off);
            end
            default: begin
            end
          endcase
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      head       <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      head       <= head_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    key      <= key_next;
    delay_r  <= delay_r_next;
    new_tag  <= new_tag_next;
    off      <= off_next;
    pend     <= pend_next;
    fin_kind <= fin_kind_next;
  end

endmodule

// ===== hdl/deadline_ordered_timer_queue.sv =====
// top level of the deadline-ordered timer queue: sequencer, entry ram, result register
// depends on dotq_pkg, dotq_seq and dotq_ram
//
// Timers sit in a ring buffer in one ram, kept sorted by deadline, and a single
// sequencer works one transaction at a time with in_stall high meanwhile. A schedule
// adds the delay to current_time, is rejected when the queue is full, and else moves
// each queued entry with a later deadline up one place before it writes the new one.
// A poll stops at the first later deadline, at the end of the queue or at the cap of
// MAX_RESULTS entries, and each entry examined needs a ram read and a pass through
// the one shared deadline comparator. The result register lets the sequencer run on
// while one result waits; out_stall only slows it when a second result is ready
// before the first is taken, and in_stall then stays high while it waits.
module deadline_ordered_timer_queue
  import dotq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic [TIME_W-1:0]  current_time,
  input  logic [DELAY_W-1:0] delay,
  input  logic [TAG_W-1:0]   tag,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         kind,
  output logic [TAG_W-1:0]   expired_tag,
  output logic [TIME_W-1:0]  expired_deadline,
  output logic               last
);

  ram_cmd_t           ram;
  result_t            res;
  logic [ENTRY_W-1:0] rd_word;
  entry_t             rd_entry;
  logic               out_free;

  assign rd_entry = entry_t'(rd_word);
  assign out_free = !out_valid || !out_stall;

  dotq_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .current_time (current_time),
    .delay        (delay),
    .tag          (tag),
    .out_free     (out_free),
    .rd_entry     (rd_entry),
    .ram          (ram),
    .res          (res)
  );

  dotq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram.wr_en),
    .wr_addr (ram.wr_addr),
    .wr_data (ram.wr_data),
    .rd_en   (ram.rd_en),
    .rd_addr (ram.rd_addr),
    .rd_data (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      kind             <= res.kind;
      expired_tag      <= res.tag;
      expired_deadline <= res.deadline;
      last             <= res.last;
    end
  end

endmodule

// ===== hdl/dotq_checker.sv =====
// port-level checks for the timer queue, bound to the top level
// depends on dotq_pkg
module dotq_checker
  import dotq_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               action,
  input logic [TIME_W-1:0]  current_time,
  input logic [DELAY_W-1:0] delay,
  input logic [TAG_W-1:0]   tag,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         kind,
  input logic [TAG_W-1:0]   expired_tag,
  input logic [TIME_W-1:0]  expired_deadline,
  input logic               last
);

  // a waiting result holds until taken
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(expired_tag)
      && $stable(expired_deadline) && $stable(last))
    else $error("stalled result changed");

  // a stalled input transaction holds until taken
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(action) && $stable(current_time)
      && $stable(delay) && $stable(tag))
    else $error("stalled input changed");

  // status results stand alone
  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_EXPIRED |-> last)
    else $error("status result without last");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_EXPIRED |-> expired_tag == '0 && expired_deadline == '0)
    else $error("status result carries entry fields");

  // one transaction in flight at a time
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("new transaction taken while busy");

endmodule

bind deadline_ordered_timer_queue dotq_checker u_dotq_checker (.*);
